// ===== rtl/core/btp_pkg.sv =====
// Shared types and constants for the block transposition permuter.
package btp_pkg;

  localparam int MAX_BLOCK_DEF = 16;
  localparam int KEY_SLOTS     = 16;
  localparam int LEN_W         = 5;
  localparam int SLOT_W        = 4;
  localparam int KEY_W         = KEY_SLOTS * SLOT_W;
  localparam int SYM_W         = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = KEY_W;
  localparam int QDEPTH        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_KEY   = 1'b1;

  localparam logic [LEN_W-1:0] KEY_LENGTH_RST = 5'd16;
  localparam logic [KEY_W-1:0] PERM_KEY_RST   = 64'hFEDC_BA98_7654_3210;

  // Flushed block handed from front to back.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] held;
    logic             eom;
  } desc_t;

  // Store write from the front.
  typedef struct packed {
    logic             we;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [SYM_W-1:0] data;
  } wr_t;

  // Bank handed back once all its words are read.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== rtl/core/btp_front.sv =====
// Front end: fills the store banks and queues each flushed block.
module btp_front #(
  parameter int MAX_BLOCK = btp_pkg::MAX_BLOCK_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [btp_pkg::SYM_W-1:0] symbol,
  input  logic                      end_of_message,
  input  logic [btp_pkg::LEN_W-1:0] eff_len,
  input  logic                      q_full,
  output logic                      push,
  output btp_pkg::desc_t            push_desc,
  output btp_pkg::wr_t              wr,
  input  btp_pkg::rel_t             rel,
  output logic [1:0]                busy
);

  logic [btp_pkg::LEN_W-1:0] fill, fill_next, fill_inc;
  logic                      wr_bank, wr_bank_next;
  logic [1:0]                busy_next;
  logic                      accept, flush;

  always_comb begin
    in_stall  = busy[wr_bank] || q_full;
    accept    = in_valid && !in_stall;
    fill_inc  = fill + 5'd1;
    flush     = (fill_inc >= eff_len) || end_of_message;

    wr.we     = accept && (int'(fill) < MAX_BLOCK);
    wr.bank   = wr_bank;
    wr.idx    = fill;
    wr.data   = symbol;

    push           = accept && flush;
    push_desc.bank = wr_bank;
    push_desc.held = (fill_inc < eff_len) ? fill_inc : eff_len;
    push_desc.eom  = end_of_message;

    fill_next    = fill;
    wr_bank_next = wr_bank;
    busy_next    = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      fill_next = fill_inc;
    end
    // Close the bank and switch to the other one.
    if (push) begin
      fill_next          = '0;
      wr_bank_next       = ~wr_bank;
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      wr_bank <= 1'b0;
      busy    <= '0;
    end else begin
      fill    <= fill_next;
      wr_bank <= wr_bank_next;
      busy    <= busy_next;
    end
  end

endmodule

// ===== rtl/core/btp_queue.sv =====
// Short descriptor queue between front and back.
module btp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  btp_pkg::desc_t push_desc,
  input  logic           pop,
  output btp_pkg::desc_t head,
  output logic           full,
  output logic           empty
);

  localparam int PW = (btp_pkg::QDEPTH > 1) ? $clog2(btp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(btp_pkg::QDEPTH + 1);

  btp_pkg::desc_t entry [btp_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  always_comb begin
    head  = entry[rd_ptr];
    full  = (int'(count) == btp_pkg::QDEPTH);
    empty = (count == '0);
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (int'(wr_ptr) == btp_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (int'(rd_ptr) == btp_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

// ===== rtl/core/btp_back.sv =====
// Back end: holds the store banks and emits each block in key order.
module btp_back #(
  parameter int MAX_BLOCK = btp_pkg::MAX_BLOCK_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  btp_pkg::wr_t              wr,
  input  logic                      q_empty,
  input  btp_pkg::desc_t            head,
  output logic                      pop,
  output btp_pkg::rel_t             rel,
  input  logic [btp_pkg::LEN_W-1:0] eff_len,
  input  logic [btp_pkg::KEY_W-1:0] perm_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [btp_pkg::SYM_W-1:0] plain_symbol,
  output logic                      block_last,
  output logic                      message_last
);

  localparam int AW = $clog2(MAX_BLOCK);

  logic [btp_pkg::SYM_W-1:0]     mem [2][MAX_BLOCK];

  btp_pkg::bk_state_t            state, state_next;
  logic [btp_pkg::KEY_SLOTS-1:0] pending, pending_next, pick, mask;
  logic [btp_pkg::SLOT_W-1:0]    idx, src, nib;
  logic                          cur_bank, cur_eom;
  logic                          load, last, can_load;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.bank][AW'(wr.idx)] <= wr.data;
    end
  end

  always_comb begin
    // Entries that point inside the held symbols of the queued block.
    mask = '0;
    nib  = '0;
    for (int m = 0; m < btp_pkg::KEY_SLOTS; m++) begin
      nib = perm_key[m*btp_pkg::SLOT_W +: btp_pkg::SLOT_W];
      mask[m] = (m < int'(eff_len)) && ({1'b0, nib} < head.held) &&
                (int'(nib) < MAX_BLOCK);
    end

    pick = pending & (~pending + 1'b1);
    idx  = '0;
    for (int i = 0; i < btp_pkg::KEY_SLOTS; i++) begin
      if (pick[i]) begin
        idx = idx | btp_pkg::SLOT_W'(i);
      end
    end
    src      = perm_key[{idx, 2'b00} +: btp_pkg::SLOT_W];
    last     = (pending & ~pick) == '0;
    can_load = !out_valid || !out_stall;

    state_next   = state;
    pending_next = pending;
    pop          = 1'b0;
    load         = 1'b0;
    rel.valid    = 1'b0;
    rel.bank     = cur_bank;
    case (state)
      btp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          pending_next = mask;
          state_next   = btp_pkg::BK_EMIT;
        end
      end
      btp_pkg::BK_EMIT: begin
        if (pending == '0) begin
          // Block with nothing to emit: drop it.
          rel.valid  = 1'b1;
          state_next = btp_pkg::BK_IDLE;
        end else if (can_load) begin
          load         = 1'b1;
          pending_next = pending & ~pick;
          if (last) begin
            rel.valid  = 1'b1;
            state_next = btp_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = btp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btp_pkg::BK_IDLE;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bank <= head.bank;
      cur_eom  <= head.eom;
    end
    if (load) begin
      plain_symbol <= mem[cur_bank][AW'(src)];
      block_last   <= last;
      message_last <= last && cur_eom;
    end
  end

endmodule

// ===== rtl/core/block_transposition_permuter_core.sv =====
// Block transposition permuter: config registers, front end, queue and back end.
// Queue, back-end state and output registers lie between a flush and its first word.
// Throughput: one input word per cycle while a bank is free and the queue has room;
// the back end emits one word per cycle unless stalled and goes idle between blocks.
// Two store banks let one block fill while the previous one drains.
// Reset clears the fill count, bank flags, queue, output valid and config to defaults.
module block_transposition_permuter_core #(
  parameter int MAX_BLOCK = btp_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [btp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btp_pkg::SYM_W-1:0]      symbol,
  input  logic                           end_of_message,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btp_pkg::SYM_W-1:0]      plain_symbol,
  output logic                           block_last,
  output logic                           message_last
);

  localparam int LEN_TOP = (MAX_BLOCK < btp_pkg::KEY_SLOTS) ? MAX_BLOCK : btp_pkg::KEY_SLOTS;

  logic [btp_pkg::LEN_W-1:0] key_length, eff_len;
  logic [btp_pkg::KEY_W-1:0] perm_key;

  logic           q_push, q_pop, q_full, q_empty;
  btp_pkg::desc_t push_desc, head;
  btp_pkg::wr_t   wr;
  btp_pkg::rel_t  rel;
  logic [1:0]     busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= btp_pkg::KEY_LENGTH_RST;
      perm_key   <= btp_pkg::PERM_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        btp_pkg::REG_KEY_LENGTH: key_length <= cfg_data[btp_pkg::LEN_W-1:0];
        btp_pkg::REG_PERM_KEY:   perm_key   <= cfg_data[btp_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the block length to 1 .. LEN_TOP.
  always_comb begin
    if (key_length == '0) begin
      eff_len = 5'd1;
    end else if (int'(key_length) > LEN_TOP) begin
      eff_len = btp_pkg::LEN_W'(LEN_TOP);
    end else begin
      eff_len = key_length;
    end
  end

  btp_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .symbol        (symbol),
    .end_of_message(end_of_message),
    .eff_len       (eff_len),
    .q_full        (q_full),
    .push          (q_push),
    .push_desc     (push_desc),
    .wr            (wr),
    .rel           (rel),
    .busy          (busy)
  );

  btp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  btp_back #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (q_pop),
    .rel         (rel),
    .eff_len     (eff_len),
    .perm_key    (perm_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plain_symbol(plain_symbol),
    .block_last  (block_last),
    .message_last(message_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> !busy[wr.bank])
    else $error("store write into a bank still draining");

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that was not closed");

  a_msg_implies_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_last) |-> block_last)
    else $error("message end without block end");

endmodule
